@@ rtl/euler_to_quaternion_core_assert.svh @@
// assertion macros for the euler to quaternion core
`ifndef EULER_TO_QUATERNION_CORE_ASSERT_SVH
`define EULER_TO_QUATERNION_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define E2Q_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
`define E2Q_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define E2Q_ASSERT_IMP(name, clk, rst, ante, cons)
`define E2Q_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ rtl/e2q_pkg.sv @@
package e2q_pkg;

   localparam int ANGLE_W       = 16;
   localparam int QUAT_W        = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int NUM_STAGES    = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
   localparam int STAGE_IDX_W   = 5;
   localparam int CW            = 34;
   localparam int SC_W          = 24;
   localparam int PAIR_W        = 48;
   localparam int HI_W          = 48;
   localparam int LO_W          = 49;
   localparam int TRIPLE_W      = 64;
   localparam int ROUND_W       = 18;
   localparam int NUM_LANES     = 3;
   localparam int NUM_TERMS     = 8;
   localparam int QUAT_LAT      = 6;

   localparam int LANE_YAW   = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_ROLL  = 2;

   localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CW-1:0] PI_Q30          = 34'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30     = 34'sd1686629713;
   localparam logic signed [CW-1:0] SC_ROUND        = 34'sd512;
   localparam logic signed [TRIPLE_W-1:0] Q14_ROUND = 64'sd35184372088832;
   localparam logic signed [ROUND_W-1:0]  SAT_HI    = 18'sd16384;
   localparam logic signed [ROUND_W-1:0]  SAT_LO    = -18'sd16384;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] yaw_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] roll_angle;
   } e2q_req_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } e2q_rsp_type;

   typedef struct packed {
      logic                 flip;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } e2q_lane_type;

   typedef struct packed {
      logic                          valid;
      e2q_lane_type [NUM_LANES-1:0] lane;
   } e2q_stage_type;

   function automatic logic signed [CW-1:0] atan_q30(input logic [STAGE_IDX_W-1:0] idx);
      logic signed [CW-1:0] v;
      case (idx)
         5'd0:    v = 34'sh3243F6A8;
         5'd1:    v = 34'sh1DAC6705;
         5'd2:    v = 34'sh0FADBAFC;
         5'd3:    v = 34'sh07F56EA6;
         5'd4:    v = 34'sh03FEAB76;
         5'd5:    v = 34'sh01FFD55B;
         5'd6:    v = 34'sh00FFFAAA;
         5'd7:    v = 34'sh007FFF55;
         5'd8:    v = 34'sh003FFFEA;
         5'd9:    v = 34'sh001FFFFD;
         5'd10:   v = 34'sh000FFFFF;
         5'd11:   v = 34'sh0007FFFF;
         5'd12:   v = 34'sh0003FFFF;
         5'd13:   v = 34'sh0001FFFF;
         5'd14:   v = 34'sh0000FFFF;
         5'd15:   v = 34'sh00007FFF;
         5'd16:   v = 34'sh00003FFF;
         5'd17:   v = 34'sh00001FFF;
         5'd18:   v = 34'sh00000FFF;
         5'd19:   v = 34'sh000007FF;
         5'd20:   v = 34'sh000003FF;
         5'd21:   v = 34'sh000001FF;
         5'd22:   v = 34'sh000000FF;
         5'd23:   v = 34'sh0000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/e2q_fold.sv @@
module e2q_fold (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  e2q_pkg::e2q_req_type  req_data,
   output e2q_pkg::e2q_stage_type stage_out
);
   import e2q_pkg::*;

   e2q_stage_type stage_ff, stage_in;
   logic signed [ANGLE_W-1:0] angle [NUM_LANES];

   assign angle[LANE_YAW]   = req_data.yaw_angle;
   assign angle[LANE_PITCH] = req_data.pitch_angle;
   assign angle[LANE_ROLL]  = req_data.roll_angle;

   always_comb begin
      logic signed [CW-1:0] z0;
      stage_in.valid = accept;
      for (int l = 0; l < NUM_LANES; l++) begin
         // half angle read as q14, widened to q30
         z0 = {{2{angle[l][ANGLE_W-1]}}, angle[l], 16'b0};
         stage_in.lane[l].x    = CORDIC_GAIN_Q30;
         stage_in.lane[l].y    = '0;
         stage_in.lane[l].flip = 1'b0;
         stage_in.lane[l].z    = z0;
         if (z0 > HALF_PI_Q30) begin
            stage_in.lane[l].z    = PI_Q30 - z0;
            stage_in.lane[l].flip = 1'b1;
         end else if (z0 < -HALF_PI_Q30) begin
            stage_in.lane[l].z    = -PI_Q30 - z0;
            stage_in.lane[l].flip = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.lane <= stage_in.lane;
   end

   assign stage_out = stage_ff;

endmodule

@@ rtl/e2q_cell.sv @@
module e2q_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [e2q_pkg::STAGE_IDX_W-1:0]     stage_idx,
   input  e2q_pkg::e2q_stage_type               stage_in_data,
   output e2q_pkg::e2q_stage_type               stage_out
);
   import e2q_pkg::*;

   e2q_stage_type stage_ff, stage_in;
   logic signed [CW-1:0] atan_val;

   assign atan_val = atan_q30(stage_idx);

   always_comb begin
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      stage_in = stage_in_data;
      for (int l = 0; l < NUM_LANES; l++) begin
         dx = stage_in_data.lane[l].y >>> stage_idx;
         dy = stage_in_data.lane[l].x >>> stage_idx;
         if (!stage_in_data.lane[l].z[CW-1]) begin
            stage_in.lane[l].x = stage_in_data.lane[l].x - dx;
            stage_in.lane[l].y = stage_in_data.lane[l].y + dy;
            stage_in.lane[l].z = stage_in_data.lane[l].z - atan_val;
         end else begin
            stage_in.lane[l].x = stage_in_data.lane[l].x + dx;
            stage_in.lane[l].y = stage_in_data.lane[l].y - dy;
            stage_in.lane[l].z = stage_in_data.lane[l].z + atan_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.lane <= stage_in.lane;
   end

   assign stage_out = stage_ff;

endmodule

@@ rtl/e2q_quat.sv @@
module e2q_quat (
   input  logic                   clock,
   input  logic                   reset,
   input  e2q_pkg::e2q_stage_type cordic_out,
   output logic                   rsp_strobe,
   output e2q_pkg::e2q_rsp_type   rsp_data
);
   import e2q_pkg::*;

`include "euler_to_quaternion_core_assert.svh"

   logic [QUAT_LAT-1:0] valid_ff, valid_in;

   logic signed [SC_W-1:0] cos_ff [NUM_LANES];
   logic signed [SC_W-1:0] sin_ff [NUM_LANES];
   logic signed [SC_W-1:0] cos_in [NUM_LANES];
   logic signed [SC_W-1:0] sin_in [NUM_LANES];

   logic signed [PAIR_W-1:0] cc_ff, ss_ff, sc_ff, cs_ff;
   logic signed [SC_W-1:0]   cy_ff, sy_ff;

   logic signed [HI_W-1:0]     hi_ff [NUM_TERMS];
   logic signed [HI_W-1:0]     hi_in [NUM_TERMS];
   logic signed [LO_W-1:0]     lo_ff [NUM_TERMS];
   logic signed [LO_W-1:0]     lo_in [NUM_TERMS];
   logic signed [TRIPLE_W-1:0] tri_ff [NUM_TERMS];
   logic signed [TRIPLE_W-1:0] tri_in [NUM_TERMS];

   logic signed [ROUND_W-1:0]  comp_ff [4];
   logic signed [ROUND_W-1:0]  comp_in [4];
   e2q_rsp_type quat_ff, quat_in;

   assign valid_in = {valid_ff[QUAT_LAT-2:0], cordic_out.valid};

   // round q30 to q20, negating the cosine of a folded angle
   always_comb begin
      logic signed [CW-1:0] xn;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      for (int l = 0; l < NUM_LANES; l++) begin
         xn = cordic_out.lane[l].flip ? -cordic_out.lane[l].x : cordic_out.lane[l].x;
         xs = xn + SC_ROUND;
         ys = cordic_out.lane[l].y + SC_ROUND;
         cos_in[l] = xs[CW-1:10];
         sin_in[l] = ys[CW-1:10];
      end
   end

   // each triple product: pair product split in two halves times one yaw term
   always_comb begin
      logic signed [PAIR_W-1:0] pair_sel [NUM_TERMS];
      logic signed [SC_W-1:0]   ang_sel  [NUM_TERMS];
      pair_sel[0] = cc_ff; ang_sel[0] = cy_ff;
      pair_sel[1] = ss_ff; ang_sel[1] = sy_ff;
      pair_sel[2] = sc_ff; ang_sel[2] = cy_ff;
      pair_sel[3] = cs_ff; ang_sel[3] = sy_ff;
      pair_sel[4] = cs_ff; ang_sel[4] = cy_ff;
      pair_sel[5] = sc_ff; ang_sel[5] = sy_ff;
      pair_sel[6] = cc_ff; ang_sel[6] = sy_ff;
      pair_sel[7] = ss_ff; ang_sel[7] = cy_ff;
      for (int k = 0; k < NUM_TERMS; k++) begin
         hi_in[k] = $signed(pair_sel[k][PAIR_W-1:SC_W]) * ang_sel[k];
         lo_in[k] = $signed({1'b0, pair_sel[k][SC_W-1:0]}) * ang_sel[k];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_TERMS; k++) begin
         tri_in[k] = (TRIPLE_W'(hi_ff[k]) <<< SC_W) + TRIPLE_W'(lo_ff[k]);
      end
   end

   always_comb begin
      logic signed [TRIPLE_W-1:0] s [4];
      s[0] = tri_ff[0] + tri_ff[1] + Q14_ROUND;
      s[1] = tri_ff[2] - tri_ff[3] + Q14_ROUND;
      s[2] = tri_ff[4] + tri_ff[5] + Q14_ROUND;
      s[3] = tri_ff[6] - tri_ff[7] + Q14_ROUND;
      for (int c = 0; c < 4; c++) begin
         comp_in[c] = s[c][TRIPLE_W-1:TRIPLE_W-ROUND_W];
      end
   end

   function automatic logic signed [QUAT_W-1:0] saturate(input logic signed [ROUND_W-1:0] v);
      logic signed [ROUND_W-1:0] r;
      r = v;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end
      return r[QUAT_W-1:0];
   endfunction

   always_comb begin
      quat_in.quat_w = saturate(comp_ff[0]);
      quat_in.quat_x = saturate(comp_ff[1]);
      quat_in.quat_y = saturate(comp_ff[2]);
      quat_in.quat_z = saturate(comp_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      cc_ff  <= cos_ff[LANE_ROLL] * cos_ff[LANE_PITCH];
      ss_ff  <= sin_ff[LANE_ROLL] * sin_ff[LANE_PITCH];
      sc_ff  <= sin_ff[LANE_ROLL] * cos_ff[LANE_PITCH];
      cs_ff  <= cos_ff[LANE_ROLL] * sin_ff[LANE_PITCH];
      cy_ff  <= cos_ff[LANE_YAW];
      sy_ff  <= sin_ff[LANE_YAW];
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      tri_ff <= tri_in;
      comp_ff <= comp_in;
      quat_ff <= quat_in;
   end

   assign rsp_strobe = valid_ff[QUAT_LAT-1];
   assign rsp_data   = quat_ff;

   `E2Q_ASSERT_IMP(a_strobe_latency, clock, reset, rsp_strobe,
                   $past(cordic_out.valid, QUAT_LAT))
   `E2Q_ASSERT_IMP(a_w_range, clock, reset, rsp_strobe,
                   (rsp_data.quat_w <= 16'sd16384) && (rsp_data.quat_w >= -16'sd16384))
   `E2Q_ASSERT_IMP(a_xyz_range, clock, reset, rsp_strobe,
                   (rsp_data.quat_x >= -16'sd16384) && (rsp_data.quat_x <= 16'sd16384) &&
                   (rsp_data.quat_y >= -16'sd16384) && (rsp_data.quat_y <= 16'sd16384) &&
                   (rsp_data.quat_z >= -16'sd16384) && (rsp_data.quat_z <= 16'sd16384))

endmodule

@@ rtl/euler_to_quaternion_core.sv @@
// yaw-pitch-roll angles (q13 radians) in, unit quaternion (q1.14, saturated) out.
// fully pipelined: an item is taken every cycle, busy stays low, and each item
// gives one result on rsp_strobe after the fold register, the chain of cordic
// cells, one per stage, and the rounding, multiply and saturation stages behind it.
// the receiver cannot stall, so each result must be captured in its strobe cycle.
module euler_to_quaternion_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  e2q_pkg::e2q_req_type  req_data,
   output logic                  rsp_strobe,
   output e2q_pkg::e2q_rsp_type  rsp_data
);
   import e2q_pkg::*;

   e2q_stage_type chain [NUM_STAGES+1];
   logic accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   e2q_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .stage_out (chain[0])
   );

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
      e2q_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .stage_idx     (STAGE_IDX_W'(g)),
         .stage_in_data (chain[g]),
         .stage_out     (chain[g+1])
      );
   end

   e2q_quat u_quat (
      .clock      (clock),
      .reset      (reset),
      .cordic_out (chain[NUM_STAGES]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ dv/euler_to_quaternion_core_tb.sv @@
module euler_to_quaternion_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import e2q_pkg::*;

   localparam int LATENCY    = 1 + NUM_STAGES + 6;
   localparam int IDLE_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   e2q_req_type req_data;
   logic        rsp_strobe;
   e2q_rsp_type rsp_data;

   e2q_rsp_type quat_expected[$];
   int          mismatch_count;
   int          items_sent;
   int          results_seen;
   int          idle_cycles;
   bit          idling_on;

   euler_to_quaternion_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // sine and cosine in q20 of half the q13 angle
   function automatic void half_angle_sincos(logic signed [ANGLE_W-1:0] ang,
                                             output longint sn, output longint cs);
      longint ang_q30, vx, vy, dx, dy;
      bit     negate_cos;
      longint atan_tab[24];
      atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                   64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                   64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                   64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                   64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                   64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      ang_q30 = longint'(ang) * 65536;
      negate_cos = 1'b0;
      vx = 652032874;
      vy = 0;
      // fold half angles outside +-pi/2
      if (ang_q30 > 64'sd1686629713) begin
         ang_q30 = 64'sd3373259426 - ang_q30;
         negate_cos = 1'b1;
      end else if (ang_q30 < -64'sd1686629713) begin
         ang_q30 = -64'sd3373259426 - ang_q30;
         negate_cos = 1'b1;
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
         dx = floor_shift(vy, i);
         dy = floor_shift(vx, i);
         if (ang_q30 >= 0) begin
            vx -= dx;
            vy += dy;
            ang_q30 -= atan_tab[i];
         end else begin
            vx += dx;
            vy -= dy;
            ang_q30 += atan_tab[i];
         end
      end
      if (negate_cos) vx = -vx;
      cs = floor_shift(vx + 512, 10);
      sn = floor_shift(vy + 512, 10);
   endfunction

   function automatic logic signed [QUAT_W-1:0] round_sat_q14(longint v60);
      longint r;
      r = floor_shift(v60 + (64'sd1 <<< 45), 46);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return QUAT_W'(r);
   endfunction

   function automatic e2q_rsp_type quaternion_of(e2q_req_type a);
      longint sy, cy, sp, cp, sr, cr;
      e2q_rsp_type q;
      half_angle_sincos(a.yaw_angle, sy, cy);
      half_angle_sincos(a.pitch_angle, sp, cp);
      half_angle_sincos(a.roll_angle, sr, cr);
      q.quat_w = round_sat_q14(cr * cp * cy + sr * sp * sy);
      q.quat_x = round_sat_q14(sr * cp * cy - cr * sp * sy);
      q.quat_y = round_sat_q14(cr * sp * cy + sr * cp * sy);
      q.quat_z = round_sat_q14(cr * cp * sy - sr * sp * cy);
      return q;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t",
               what, $signed(got), $signed(want), $realtime);
      mismatch_count++;
   endtask

   // result checker, sampled on the strobe edge
   always @(posedge clock) begin
      e2q_rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (quat_expected.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            mismatch_count++;
         end else begin
            want = quat_expected.pop_front();
            if (rsp_data.quat_w !== want.quat_w)
               report_mismatch("quat_w", rsp_data.quat_w, want.quat_w);
            if (rsp_data.quat_x !== want.quat_x)
               report_mismatch("quat_x", rsp_data.quat_x, want.quat_x);
            if (rsp_data.quat_y !== want.quat_y)
               report_mismatch("quat_y", rsp_data.quat_y, want.quat_y);
            if (rsp_data.quat_z !== want.quat_z)
               report_mismatch("quat_z", rsp_data.quat_z, want.quat_z);
         end
      end
   end

   // watchdog on cycles with nothing accepted and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("euler_to_quaternion_core regression: fail");
            $finish;
         end
      end
   end

   // sends one item; start stays high into the next call, which may drop it for a random idle gap
   task automatic send_item(e2q_req_type a);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= a;
      @(posedge clock);
      while (busy) @(posedge clock);
      quat_expected = {quat_expected, quaternion_of(a)};
      items_sent++;
   endtask

   task automatic release_start();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_angle();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom);
         1:       return 16'($signed($urandom_range(0, 40)) - 20);
         2:       return 16'(25736 - $signed($urandom_range(0, 60)));
         3:       return 16'(-25736 + $signed($urandom_range(0, 60)));
         default: return 16'($signed($urandom_range(0, 51472)) - 25736);
      endcase
   endfunction

   task automatic test_directed();
      logic signed [15:0] corner[9];
      e2q_req_type a;
      corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                 16'sd32767, -16'sd32768, 16'sd12869, 16'sd1};
      foreach (corner[i]) begin
         a.yaw_angle   = corner[i];
         a.pitch_angle = corner[(i + 3) % 9];
         a.roll_angle  = corner[(i + 6) % 9];
         send_item(a);
      end
      // full-scale codes beyond the stated range, and the fold boundaries
      a = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}; send_item(a);
      a = '{16'sh8000, 16'sh8000, 16'sh8000}; send_item(a);
      a = '{16'sh8000, 16'sh7FFF, 16'sh0000}; send_item(a);
      a = '{16'sd25736, 16'sd25736, 16'sd25736}; send_item(a);
      a = '{-16'sd25736, -16'sd25736, -16'sd25736}; send_item(a);
      a = '{16'sd25735, 16'sd25737, -16'sd25737}; send_item(a);
      a = '{16'sd0, 16'sd12868, 16'sd0}; send_item(a);
      a = '{16'sd0, -16'sd12868, 16'sd0}; send_item(a);
      a = '{16'sh5555, 16'shAAAA, 16'sh0F0F}; send_item(a);
      a = '{16'shAAAA, 16'sh5555, 16'shF0F0}; send_item(a);
      release_start();
   endtask

   task automatic test_random(int count);
      e2q_req_type a;
      repeat (count) begin
         a.yaw_angle   = random_angle();
         a.pitch_angle = random_angle();
         a.roll_angle  = random_angle();
         send_item(a);
      end
      release_start();
   endtask

   task automatic drain_results();
      while (quat_expected.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      mismatch_count = 0;
      items_sent     = 0;
      results_seen   = 0;
      idle_cycles    = 0;
      idling_on      = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(250);
      // sender holds off until the pipeline is empty
      drain_results();
      test_random(200);
      idling_on = 1'b0;
      test_random(80);

      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d angle triples (corners, fold edges, full-scale codes, random)",
               items_sent);
      $display("checked %0d quaternions with %0d mismatches", results_seen, mismatch_count);
      if (mismatch_count == 0 && quat_expected.size() == 0)
         $display("euler_to_quaternion_core regression: pass");
      else
         $display("euler_to_quaternion_core regression: fail");
      $finish;
   end

endmodule
